// ----- rtl/oll_pkg.sv -----
`timescale 1ns / 1ps

package oll_pkg;

  localparam logic [1:0] CMD_DELETE = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_SEARCH,
    S_SCHECK,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/oll_ram.sv -----
`timescale 1ns / 1ps

module oll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ordered_list_insert_delete_search.sv -----
`timescale 1ns / 1ps
// An item is accepted only while idle; its result is registered when the control leaves S_FINISH.
// Delete, rejected and unused commands, and a search of an empty list, go straight to S_FINISH.
// Insert goes to S_PLACE when appending, else S_SHIFT moves entries back, last first, then S_DRAIN.
// Search reads entries in order from the first in S_SEARCH, then S_SCHECK; one RAM read port sets both.
// in_stall holds until the result is registered, after any output stall; the next item may follow.
// Reset clears the count and the control state; the entry RAM keeps its contents.

module ordered_list_insert_delete_search
  import oll_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [6:0]  position,
  input  logic [31:0] item_value,
  input  logic [31:0] search_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [6:0]  found_position,
  output logic [6:0]  entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  state_t          state, state_next;
  logic [CW-1:0]   total;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   pos_m1;
  logic            pend;
  logic [31:0]     val;
  logic [31:0]     key;
  status_t         res_status;
  logic [6:0]      res_found;

  logic            accept;
  logic [PW-1:0]   pos_x;
  logic [PW-1:0]   tot_x;
  logic [PW-1:0]   pos_m1_x;
  logic            pos_ok;
  logic            needs_shift;
  logic            is_full;
  logic            is_empty;
  logic [AW-1:0]   last_idx;
  logic            match;
  logic            out_free;
  logic [AW:0]     found_x;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign pos_x       = PW'(position);
  assign tot_x       = PW'(total);
  assign pos_m1_x    = pos_x - PW'(1);
  assign pos_ok      = (pos_x != '0) && (pos_x <= tot_x + PW'(1));
  assign needs_shift = (pos_x <= tot_x);
  assign is_full     = (total == CW'(CAPACITY));
  assign is_empty    = (total == '0);
  assign last_idx    = AW'(total - CW'(1));
  assign match       = pend && (ram_rdata == key);
  assign out_free    = !out_valid || !out_stall;
  assign found_x     = {1'b0, raddr} + (AW + 1)'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (command == CMD_INSERT && pos_ok && !is_full) begin
            state_next = needs_shift ? S_SHIFT : S_PLACE;
          end else if (command == CMD_SEARCH && !is_empty) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        if (idx == pos_m1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_PLACE;
      S_PLACE:  state_next = S_FINISH;
      S_SEARCH: begin
        priority if (match) begin
          state_next = S_FINISH;
        end else if (idx == last_idx) begin
          state_next = S_SCHECK;
        end
      end
      S_SCHECK: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = raddr + AW'(1);
    ram_wdata = ram_rdata;
    unique case (state)
      S_SHIFT, S_DRAIN: begin
        ram_we = pend;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1;
        ram_wdata = val;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  oll_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SHIFT) || (state == S_SEARCH && !match);
      if (accept && command == CMD_DELETE && !is_empty) begin
        total <= total - CW'(1);
      end
      if (state == S_PLACE) begin
        total <= total + CW'(1);
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val       <= item_value;
      key       <= search_key;
      pos_m1    <= AW'(pos_m1_x);
      res_found <= '0;
      idx       <= (command == CMD_INSERT) ? last_idx : '0;
      if (command == CMD_DELETE) begin
        res_status <= is_empty ? ST_EMPTY : ST_OK;
      end else if (command == CMD_INSERT) begin
        if (!pos_ok) begin
          res_status <= ST_BADPOS;
        end else if (is_full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
      end else if (command == CMD_SEARCH) begin
        res_status <= is_empty ? ST_EMPTY : ST_NOTFOUND;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (state == S_SHIFT) begin
      raddr <= idx;
      idx   <= idx - AW'(1);
    end
    if (state == S_SEARCH && !match) begin
      raddr <= idx;
      idx   <= idx + AW'(1);
    end
    if ((state == S_SEARCH || state == S_SCHECK) && match) begin
      res_status <= ST_OK;
      res_found  <= 7'(found_x);
    end
    if (state == S_FINISH && out_free) begin
      status         <= res_status;
      found_position <= res_found;
      entry_count    <= 7'(total);
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_SHIFT) |-> !is_full)
    else $error("Entries are being moved in a full list.");

  assert property (@(posedge clk) disable iff (rst)
      ram_we |-> (state == S_SHIFT || state == S_DRAIN || state == S_PLACE))
    else $error("The entry RAM is written outside an insert.");

  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend)
    else $error("A RAM read is still pending while idle.");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_SCHECK || state == S_DRAIN) |-> pend)
    else $error("The last read of a pass was not issued.");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("A finished result was not registered.");

endmodule
